// ===== rtl/twd_pkg.sv =====
// ----------------------------------------------------------------------------
// twd_pkg
// Shared types and constants for the wiring-diagram builder: payload structs,
// result kinds, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package twd_pkg;

	localparam int LINE_W = 5;              // line number / position width
	localparam int CNT_W  = 6;              // line count width
	localparam int RES_W  = 5;              // per-item result counter width
	localparam int MAX_POS = 32;            // positions reachable by a 5-bit index
	localparam int MAX_LINES = 32;          // lines in the diagram, at most MAX_POS
	localparam logic [RES_W-1:0] MAX_RESULTS = 5'd18;

	typedef enum logic [1:0] {
		KIND_CROSS   = 2'd0,
		KIND_PAIR    = 2'd1,
		KIND_INVALID = 2'd2,
		KIND_END     = 2'd3
	} twd_kind_t;

	typedef struct packed {
		logic [LINE_W-1:0] gen_index;
		logic              last_gen;
	} twd_in_t;

	typedef struct packed {
		twd_kind_t         result_kind;
		logic [LINE_W-1:0] line_a;
		logic [LINE_W-1:0] line_b;
		logic [CNT_W-1:0]  line_count;
		logic              last_result;
	} twd_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWAP,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_END
	} twd_state_t;

	// Controller to datapath
	typedef struct packed {
		logic      cap_in;    // latch the incoming item
		logic      rd_in;     // read the pair at the incoming index
		logic      rd_scan0;  // read the pair at position 0
		logic      rd_next;   // advance the scan and read the next pair
		logic      wr_swap;   // write the swapped pair back
		logic      emit;      // load the output register
		twd_kind_t kind;      // kind of result to load
		logic      set_prev;
		logic      clr_prev;
		logic      finish;    // back to identity
	} twd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_range;  // incoming index names a real pair
		logic in_last;   // incoming item is the last
		logic last_q;    // held item is the last
		logic out_free;  // output register can take a result
		logic asc;       // pair just read is ascending
		logic prev;      // previous scanned pair was ascending
		logic room;      // room left for a pair ahead of the end result
		logic more;      // further scan positions remain
	} twd_sts_t;

endpackage

// ===== rtl/transposition_word_to_wiring_diagram_top.sv =====
// Flow: an accepted in-range item is read from the banks, then in ST_SWAP the
// crossing result is loaded and the swapped pair written back, once the output
// register is free; an ignored item that is not last is only captured. No new
// item is taken until the block is back in ST_IDLE. The last item adds a scan,
// one bank read per scanned position, n = largest index + 2, then the end result.
// Reset: asynchronous; the permutation reads as identity at once (valid bits).
// ----------------------------------------------------------------------------
// transposition_word_to_wiring_diagram_top
// Builds a wiring diagram from a stream of adjacent transpositions: crossing,
// parallel-pair, invalid and end results.
// ----------------------------------------------------------------------------
module transposition_word_to_wiring_diagram_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  twd_pkg::twd_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output twd_pkg::twd_out_t out_data
);

	twd_pkg::twd_cmd_t cmd;
	twd_pkg::twd_sts_t sts;

	// Sequencer
	twd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Permutation store and result path
	twd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/twd_ctrl.sv =====
// ----------------------------------------------------------------------------
// twd_ctrl
// Sequencer: swap for each in-range item, then on the last item a scan of adjacent
// positions and the end result.
// ----------------------------------------------------------------------------
module twd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  twd_pkg::twd_sts_t sts,
	output twd_pkg::twd_cmd_t cmd
);

	twd_pkg::twd_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.kind = twd_pkg::KIND_CROSS;
		unique case (state_q)
			twd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					if (sts.in_range) begin
						cmd.rd_in = 1'b1;
						state_d   = twd_pkg::ST_SWAP;
					end else if (sts.in_last) begin
						state_d = twd_pkg::ST_SCAN_RD;
					end
				end
			end
			twd_pkg::ST_SWAP: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = twd_pkg::KIND_CROSS;
					cmd.wr_swap = 1'b1;
					state_d     = sts.last_q ? twd_pkg::ST_SCAN_RD : twd_pkg::ST_IDLE;
				end
			end
			twd_pkg::ST_SCAN_RD: begin
				cmd.rd_scan0 = 1'b1;
				state_d      = twd_pkg::ST_SCAN_CHK;
			end
			twd_pkg::ST_SCAN_CHK: begin
				if (sts.asc) begin
					if (!sts.room) begin
						state_d = twd_pkg::ST_END;
					end else if (sts.prev) begin
						// a line shared by two pairs stops the scan
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.kind = twd_pkg::KIND_INVALID;
							state_d  = twd_pkg::ST_END;
						end
					end else if (sts.out_free) begin
						cmd.emit     = 1'b1;
						cmd.kind     = twd_pkg::KIND_PAIR;
						cmd.set_prev = 1'b1;
						if (sts.more) begin
							cmd.rd_next = 1'b1;
						end else begin
							state_d = twd_pkg::ST_END;
						end
					end
				end else begin
					cmd.clr_prev = 1'b1;
					if (sts.more) begin
						cmd.rd_next = 1'b1;
					end else begin
						state_d = twd_pkg::ST_END;
					end
				end
			end
			twd_pkg::ST_END: begin
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.kind   = twd_pkg::KIND_END;
					cmd.finish = 1'b1;
					state_d    = twd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = twd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/twd_datapath.sv =====
// ----------------------------------------------------------------------------
// twd_datapath
// Permutation store split into even and odd position banks, so that any
// adjacent pair is one read and one write per bank. Valid bits make an
// unwritten entry read as its own position. Also holds the scan state and
// the output register.
// ----------------------------------------------------------------------------
module twd_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  twd_pkg::twd_in_t  in_data,
	input  twd_pkg::twd_cmd_t cmd,
	output twd_pkg::twd_sts_t sts,
	output logic              out_valid,
	input  logic              out_ready,
	output twd_pkg::twd_out_t out_data
);

	localparam int LW    = twd_pkg::LINE_W;
	localparam int CW    = twd_pkg::CNT_W;
	localparam int DEPTH = (twd_pkg::MAX_LINES < twd_pkg::MAX_POS) ?
		twd_pkg::MAX_LINES : twd_pkg::MAX_POS;
	localparam int HALF  = (DEPTH + 1) / 2;
	localparam int AW    = $clog2(HALF);
	localparam logic [8:0]    ML9 = 9'(twd_pkg::MAX_LINES);
	localparam logic [CW-1:0] LIM = CW'(DEPTH);

	// Banks and their valid bits
	logic [LW-1:0] bank_even [HALF];
	logic [LW-1:0] bank_odd  [HALF];
	logic [HALF-1:0] ev_vld_q, od_vld_q;

	// Item and scan registers
	logic [LW-1:0]              g_q;
	logic                       last_q;
	logic [LW-1:0]              i_q;
	logic                       prev_q;
	logic [twd_pkg::RES_W-1:0]  k_q;
	logic [LW-1:0]              largest_q;

	// Read registers
	logic [LW-1:0] ev_rd_q, od_rd_q;
	logic          ev_ok_q, od_ok_q;
	logic [AW-1:0] ev_adr_q, od_adr_q;
	logic          rd_par_q;

	logic              out_valid_q;
	twd_pkg::twd_out_t out_q;

	// Read position and bank addresses
	logic [LW-1:0] rd_pos;
	logic          rd_en;
	logic [LW:0]   rd_pos_inc;
	logic [LW-1:0] rd_pos_half;
	logic [AW-1:0] rd_ea, rd_oa;

	always_comb begin
		rd_en  = cmd.rd_in | cmd.rd_scan0 | cmd.rd_next;
		rd_pos = i_q + LW'(1);
		if (cmd.rd_in) begin
			rd_pos = in_data.gen_index;
		end else if (cmd.rd_scan0) begin
			rd_pos = '0;
		end
		rd_pos_inc  = {1'b0, rd_pos} + (LW+1)'(1);
		rd_pos_half = rd_pos >> 1;
		rd_ea       = rd_pos_inc[AW:1];
		rd_oa       = rd_pos_half[AW-1:0];
	end

	// Registered bank reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			ev_rd_q  <= bank_even[rd_ea];
			od_rd_q  <= bank_odd[rd_oa];
			ev_adr_q <= rd_ea;
			od_adr_q <= rd_oa;
			rd_par_q <= rd_pos[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_ok_q <= 1'b0;
			od_ok_q <= 1'b0;
		end else if (rd_en) begin
			ev_ok_q <= ev_vld_q[rd_ea];
			od_ok_q <= od_vld_q[rd_oa];
		end
	end

	// Unwritten entries read as their own position
	logic [LW-1:0] ev_line, od_line, line_lo, line_hi;

	always_comb begin
		ev_line = ev_ok_q ? ev_rd_q : LW'({ev_adr_q, 1'b0});
		od_line = od_ok_q ? od_rd_q : LW'({od_adr_q, 1'b1});
		line_lo = rd_par_q ? od_line : ev_line;
		line_hi = rd_par_q ? ev_line : od_line;
	end

	// Swap write-back at the held index
	logic [LW:0]   wr_pos_inc;
	logic [LW-1:0] wr_pos_half;
	logic [AW-1:0] wr_ea, wr_oa;
	logic [LW-1:0] wr_ev_data, wr_od_data;

	always_comb begin
		wr_pos_inc  = {1'b0, g_q} + (LW+1)'(1);
		wr_pos_half = g_q >> 1;
		wr_ea       = wr_pos_inc[AW:1];
		wr_oa       = wr_pos_half[AW-1:0];
		// position g takes the line from g+1 and the other way round
		wr_ev_data  = g_q[0] ? line_lo : line_hi;
		wr_od_data  = g_q[0] ? line_hi : line_lo;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_swap) begin
			bank_even[wr_ea] <= wr_ev_data;
			bank_odd[wr_oa]  <= wr_od_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_vld_q <= '0;
			od_vld_q <= '0;
		end else if (cmd.finish) begin
			ev_vld_q <= '0;
			od_vld_q <= '0;
		end else if (cmd.wr_swap) begin
			ev_vld_q[wr_ea] <= 1'b1;
			od_vld_q[wr_oa] <= 1'b1;
		end
	end

	// Item, scan and largest-index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q       <= '0;
			last_q    <= 1'b0;
			i_q       <= '0;
			prev_q    <= 1'b0;
			k_q       <= '0;
			largest_q <= '0;
		end else begin
			if (cmd.cap_in) begin
				g_q    <= in_data.gen_index;
				last_q <= in_data.last_gen;
				prev_q <= 1'b0;
				k_q    <= '0;
			end else begin
				if (cmd.set_prev) begin
					prev_q <= 1'b1;
				end else if (cmd.clr_prev) begin
					prev_q <= 1'b0;
				end
				if (cmd.emit) begin
					k_q <= k_q + twd_pkg::RES_W'(1);
				end
			end
			if (cmd.rd_scan0) begin
				i_q <= '0;
			end else if (cmd.rd_next) begin
				i_q <= i_q + LW'(1);
			end
			if (cmd.finish) begin
				largest_q <= '0;
			end else if (cmd.wr_swap && (g_q > largest_q)) begin
				largest_q <= g_q;
			end
		end
	end

	// Line count, clamped to the stored depth
	logic [CW-1:0] n_full, n_lines;
	logic [CW-1:0] i_plus2;

	always_comb begin
		n_full  = {1'b0, largest_q} + CW'(2);
		n_lines = (n_full > LIM) ? LIM : n_full;
		i_plus2 = {1'b0, i_q} + CW'(2);
	end

	// Status to the controller
	always_comb begin
		sts.in_range = (({4'b0, in_data.gen_index} + 9'd1) < ML9);
		sts.in_last  = in_data.last_gen;
		sts.last_q   = last_q;
		sts.out_free = !out_valid_q || out_ready;
		sts.asc      = line_lo < line_hi;
		sts.prev     = prev_q;
		sts.room     = k_q < (twd_pkg::MAX_RESULTS - twd_pkg::RES_W'(1));
		sts.more     = i_plus2 < n_lines;
	end

	// Result assembly
	twd_pkg::twd_out_t res_d;

	always_comb begin
		res_d             = '0;
		res_d.result_kind = cmd.kind;
		case (cmd.kind)
			twd_pkg::KIND_CROSS: begin
				res_d.line_a      = line_lo;
				res_d.line_b      = line_hi;
				res_d.last_result = !last_q;
			end
			twd_pkg::KIND_END: begin
				res_d.line_count  = n_lines;
				res_d.last_result = 1'b1;
			end
			default: begin
				res_d.line_a = line_lo;
				res_d.line_b = line_hi;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== sim/tb_transposition_word_to_wiring_diagram_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_transposition_word_to_wiring_diagram_top
// Self-checking bench for the wiring-diagram builder. A short table of
// directed items, with hand-typed results for the plain cases, is followed by
// random transposition words. Every result is compared field by field with its
// hand-typed value or a behavioural copy of the line permutation in the bench.
// Both sides idle at random, with one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_transposition_word_to_wiring_diagram_top;

	// Directed table row: item plus, where typed, how many hand-written results
	typedef struct packed {
		logic [twd_pkg::LINE_W-1:0] gen;
		logic                       last;
		logic                       typed;
		logic [2:0]                 n_exp;
	} dir_row_t;

	localparam int DIR_ROWS_N = 24;
	localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
		'{5'd31, 1'b1, 1'b1, 3'd2},   // ignored index, closes an empty word
		'{5'd31, 1'b0, 1'b1, 3'd0},   // ignored index, nothing at all
		'{5'd0,  1'b1, 1'b1, 3'd2},   // lowest position, closes at once
		'{5'd30, 1'b1, 1'b1, 3'd4},   // highest position, shared line in scan
		'{5'd0,  1'b0, 1'b0, 3'd0},   // longest word on three lines
		'{5'd1,  1'b0, 1'b0, 3'd0},
		'{5'd0,  1'b1, 1'b0, 3'd0},
		'{5'd30, 1'b0, 1'b0, 3'd0},   // top pair twice: all 32 lines, top restored
		'{5'd30, 1'b0, 1'b0, 3'd0},
		'{5'd1,  1'b0, 1'b0, 3'd0},   // odd positions: many parallel pairs
		'{5'd3,  1'b0, 1'b0, 3'd0},
		'{5'd5,  1'b0, 1'b0, 3'd0},
		'{5'd7,  1'b0, 1'b0, 3'd0},
		'{5'd9,  1'b0, 1'b0, 3'd0},
		'{5'd11, 1'b0, 1'b0, 3'd0},
		'{5'd13, 1'b0, 1'b0, 3'd0},
		'{5'd15, 1'b0, 1'b0, 3'd0},
		'{5'd17, 1'b0, 1'b0, 3'd0},
		'{5'd19, 1'b0, 1'b0, 3'd0},
		'{5'd21, 1'b0, 1'b0, 3'd0},
		'{5'd23, 1'b0, 1'b0, 3'd0},
		'{5'd25, 1'b0, 1'b0, 3'd0},
		'{5'd27, 1'b0, 1'b0, 3'd0},
		'{5'd29, 1'b1, 1'b0, 3'd0}    // full item: crossing, 16 pairs, end
	};

	localparam int DIR_EXPECT_N = 8;
	localparam twd_pkg::twd_out_t DIR_EXPECT [DIR_EXPECT_N] = '{
		'{twd_pkg::KIND_PAIR,    5'd0,  5'd1,  6'd0,  1'b0},
		'{twd_pkg::KIND_END,     5'd0,  5'd0,  6'd2,  1'b1},
		'{twd_pkg::KIND_CROSS,   5'd0,  5'd1,  6'd0,  1'b0},
		'{twd_pkg::KIND_END,     5'd0,  5'd0,  6'd2,  1'b1},
		'{twd_pkg::KIND_CROSS,   5'd30, 5'd31, 6'd0,  1'b0},
		'{twd_pkg::KIND_PAIR,    5'd0,  5'd1,  6'd0,  1'b0},
		'{twd_pkg::KIND_INVALID, 5'd1,  5'd2,  6'd0,  1'b0},
		'{twd_pkg::KIND_END,     5'd0,  5'd0,  6'd32, 1'b1}
	};

	localparam int HOLD_CYCLES  = 200;
	localparam int HOLD_AT      = 60;
	localparam int DRAIN_CYCLES = 60;
	localparam int ITEMS_N      = 200;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	twd_pkg::twd_in_t  in_data;
	logic              out_valid;
	logic              out_ready = 1'b0;
	twd_pkg::twd_out_t out_data;

	// Bench copy of the permutation and the results still owed by the block
	logic [twd_pkg::LINE_W-1:0] line_at [twd_pkg::MAX_POS];
	logic [twd_pkg::LINE_W-1:0] widest_index;
	twd_pkg::twd_out_t          step_results [$];
	twd_pkg::twd_out_t          due_results [$];

	int  errors       = 0;
	int  results_seen = 0;
	int  items_sent   = 0;
	int  words_closed = 0;
	bit  quiet        = 1'b0;
	bit  hold_done    = 1'b0;
	int  hold_left    = 0;

	transposition_word_to_wiring_diagram_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic report_mismatch(input string msg);
		begin
			errors++;
			$display("ERROR @%0t: %s", $time, msg);
		end
	endtask

	task automatic identity_lines();
		begin
			for (int i = 0; i < twd_pkg::MAX_POS; i++)
				line_at[i] = twd_pkg::LINE_W'(i);
			widest_index = '0;
		end
	endtask

	// Swap, then on the closing item scan for parallel pairs and restart
	task automatic apply_transposition(input twd_pkg::twd_in_t it);
		logic [twd_pkg::LINE_W-1:0] first_line;
		logic [twd_pkg::LINE_W-1:0] second_line;
		int                         span;
		bit                         prev_asc;
		twd_pkg::twd_out_t          r;
		begin
			step_results.delete();
			if (int'(it.gen_index) + 1 < twd_pkg::MAX_POS) begin
				first_line  = line_at[it.gen_index];
				second_line = line_at[it.gen_index + 1];
				line_at[it.gen_index]     = second_line;
				line_at[it.gen_index + 1] = first_line;
				if (it.gen_index > widest_index)
					widest_index = it.gen_index;
				r = '{twd_pkg::KIND_CROSS, first_line, second_line, 6'd0, 1'b0};
				step_results = {step_results, r};
			end
			if (it.last_gen) begin
				span = int'(widest_index) + 2;
				if (span > twd_pkg::MAX_POS)
					span = twd_pkg::MAX_POS;
				prev_asc = 1'b0;
				for (int i = 0; i + 1 < span; i++) begin
					if (line_at[i] < line_at[i + 1]) begin
						// keep room for the end result
						if (step_results.size() >= int'(twd_pkg::MAX_RESULTS) - 1)
							break;
						if (prev_asc) begin
							r = '{twd_pkg::KIND_INVALID, line_at[i], line_at[i + 1],
								6'd0, 1'b0};
							step_results = {step_results, r};
							break;
						end
						r = '{twd_pkg::KIND_PAIR, line_at[i], line_at[i + 1], 6'd0, 1'b0};
						step_results = {step_results, r};
						prev_asc = 1'b1;
					end else begin
						prev_asc = 1'b0;
					end
				end
				r = '{twd_pkg::KIND_END, 5'd0, 5'd0, twd_pkg::CNT_W'(span), 1'b0};
				step_results = {step_results, r};
				identity_lines();
				words_closed++;
			end
			if (step_results.size() > 0)
				step_results[step_results.size() - 1].last_result = 1'b1;
		end
	endtask

	// Random idle gap ahead of an item, skipped during the quiet stretch
	task automatic idle_gap();
		begin
			if (!quiet && $urandom_range(0, 99) < 23) begin
				in_valid <= 1'b0;
				in_data  <= twd_pkg::twd_in_t'($urandom);
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	endtask

	// Present one item, wait for acceptance, then update the bench permutation
	task automatic offer_item(input twd_pkg::twd_in_t it, input bit use_prediction);
		begin
			in_valid <= 1'b1;
			in_data  <= it;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			apply_transposition(it);
			if (use_prediction)
				foreach (step_results[k])
					due_results = {due_results, step_results[k]};
			items_sent++;
		end
	endtask

	task automatic check_result(input twd_pkg::twd_out_t got);
		twd_pkg::twd_out_t want;
		begin
			results_seen++;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %s a %0d b %0d",
					got.result_kind.name(), got.line_a, got.line_b));
			end else begin
				want = due_results.pop_front();
				if (got.result_kind !== want.result_kind)
					report_mismatch($sformatf("result %0d kind: want %0d got %0d",
						results_seen, want.result_kind, got.result_kind));
				if (got.line_a !== want.line_a)
					report_mismatch($sformatf("result %0d line_a: want %0d got %0d",
						results_seen, want.line_a, got.line_a));
				if (got.line_b !== want.line_b)
					report_mismatch($sformatf("result %0d line_b: want %0d got %0d",
						results_seen, want.line_b, got.line_b));
				if (got.line_count !== want.line_count)
					report_mismatch($sformatf("result %0d line_count: want %0d got %0d",
						results_seen, want.line_count, got.line_count));
				if (got.last_result !== want.last_result)
					report_mismatch($sformatf("result %0d last_result: want %0d got %0d",
						results_seen, want.last_result, got.last_result));
			end
		end
	endtask

	// Output side: check accepted results, then pick next cycle's ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_result(out_data);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (quiet) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 23);
			end
		end
	end

	// Stimulus: reset, directed table, random words, drain
	initial begin
		twd_pkg::twd_in_t it;
		int               typed_at;
		int               word_len;
		int               span;
		bit               paused;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		typed_at = 0;
		paused   = 1'b0;
		identity_lines();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < DIR_ROWS_N; r++) begin
			idle_gap();
			it.gen_index = DIR_ROWS[r].gen;
			it.last_gen  = DIR_ROWS[r].last;
			offer_item(it, !DIR_ROWS[r].typed);
			if (DIR_ROWS[r].typed)
				repeat (DIR_ROWS[r].n_exp) begin
					due_results = {due_results, DIR_EXPECT[typed_at]};
					typed_at++;
				end
		end

		// random words, mostly over a few lines, some wide, some stray indices
		while (items_sent < ITEMS_N) begin
			quiet <= (items_sent >= 150 && items_sent < 190);
			if (!paused && items_sent >= 120) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				while (due_results.size() > 0)
					@(posedge clk);
				repeat (DRAIN_CYCLES) @(posedge clk);
			end
			word_len = $urandom_range(1, 10);
			span = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 30);
			for (int j = 0; j < word_len; j++) begin
				idle_gap();
				it.gen_index = twd_pkg::LINE_W'($urandom_range(0, span));
				if ($urandom_range(0, 15) == 0)
					it.gen_index = 5'd31;
				it.last_gen = (j == word_len - 1);
				offer_item(it, 1'b1);
			end
		end
		in_valid <= 1'b0;
		quiet    <= 1'b0;

		// drain and let any stray result show up
		while (due_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d items over %0d closed words, %0d results checked, %0d errors",
			items_sent, words_closed, results_seen, errors);
		$display("Summary: ignored indices, shared-line scans and a full 18-result item covered");
		if (errors == 0)
			$display("tb_transposition_word_to_wiring_diagram_top: PASS");
		else
			$display("tb_transposition_word_to_wiring_diagram_top: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#(3_000_000);
		$display("tb_transposition_word_to_wiring_diagram_top: FAIL");
		$finish;
	end

endmodule
